FILE: sv/assert_macros.svh
// Assertion macros used by the decode core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rvdec_pkg.sv
// Opcode and ALU codes, decoded control type and decode function.
package rvdec_pkg;

  localparam logic [6:0] OPC_JAL    = 7'd111;
  localparam logic [6:0] OPC_JALR   = 7'd103;
  localparam logic [6:0] OPC_BRANCH = 7'd99;
  localparam logic [6:0] OPC_STORE  = 7'd35;
  localparam logic [6:0] OPC_OP     = 7'd51;
  localparam logic [6:0] OPC_OPIMM  = 7'd19;
  localparam logic [6:0] OPC_LOAD   = 7'd3;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SR  = 3'd5;

  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_SRL = 4'd5;
  localparam logic [3:0] ALU_SUB = 4'd8;
  localparam logic [3:0] ALU_SRA = 4'd9;

  localparam logic [6:0] SHIFT_IMM_UPPER = 7'd5;

  typedef struct packed {
    logic        jump;
    logic        pc_relative_select;
    logic        reg_write_next;
    logic        branch_flag;
    logic [3:0]  alu_operation;
    logic        alu_uses_immediate;
    logic        store_flag;
    logic        load_flag;
    logic        shift_immediate;
    logic [11:0] immediate;
    logic        reg_write_current;
  } ctrl_t;

  function automatic logic [3:0] alu_for_arith(input logic [2:0] f3, input logic alt,
                                               input logic is_reg);
    logic [3:0] op;
    if (f3 == F3_ADD && is_reg) begin
      op = alt ? ALU_SUB : ALU_ADD;
    end else if (f3 == F3_SR) begin
      op = alt ? ALU_SRA : ALU_SRL;
    end else begin
      op = {1'b0, f3};
    end
    return op;
  endfunction

  function automatic ctrl_t decode(input logic [6:0] opc, input logic [2:0] f3,
                                   input logic [6:0] f7, input logic [4:0] rs2,
                                   input logic [4:0] rd, input logic clr);
    ctrl_t c;
    logic [11:0] imm_i;
    logic [11:0] imm_j;
    logic [11:0] imm_s;
    logic [11:0] imm_b;
    logic [11:0] imm_sh;
    imm_i  = {f7, rs2};
    imm_j  = {f3[0], rs2[0], f7[5:0], rs2[4:1]};
    imm_s  = {f7, rd};
    imm_b  = {f7[6], rd[0], f7[5:0], rd[4:1]};
    imm_sh = {SHIFT_IMM_UPPER, rs2};
    c = '0;
    c.immediate = imm_i;
    case (opc)
      OPC_JAL: begin
        c.jump = 1'b1;
        c.pc_relative_select = 1'b1;
        c.immediate = imm_j;
      end
      OPC_JALR: begin
        c.jump = 1'b1;
      end
      OPC_BRANCH: begin
        c.pc_relative_select = 1'b1;
        c.branch_flag = 1'b1;
        c.alu_operation = ALU_SUB;
        c.immediate = imm_b;
      end
      OPC_LOAD: begin
        c.reg_write_next = 1'b1;
        c.load_flag = 1'b1;
      end
      OPC_STORE: begin
        // store also raises the branch flag
        c.branch_flag = 1'b1;
        c.store_flag = 1'b1;
        c.immediate = imm_s;
      end
      OPC_OP: begin
        c.reg_write_next = 1'b1;
        c.alu_operation = alu_for_arith(f3, f7[6], 1'b1);
      end
      OPC_OPIMM: begin
        c.reg_write_next = 1'b1;
        c.alu_uses_immediate = 1'b1;
        c.shift_immediate = 1'b1;
        c.alu_operation = alu_for_arith(f3, f7[6], 1'b0);
        if (f3 == F3_SLL || f3 == F3_SR) begin
          c.immediate = imm_sh;
        end
      end
      default: begin
      end
    endcase
    if (clr) begin
      c = '0;
    end
    // current-stage write ignores clear
    c.reg_write_current = (opc == OPC_JAL) || (opc == OPC_JALR);
    return c;
  endfunction

endpackage

FILE: sv/rv32i_control_and_immediate_decode_core.sv
// RV32I control and immediate decoder: input register, decode, result register.
//
// Input channel (in_*): one instruction's opcode, funct3, funct7, rs2 and rd
// fields plus a clear bit. An item is taken on a rising edge with in_valid
// high and in_stall low.
// Result channel (out_*): control flags, ALU operation code and the selected
// 12-bit immediate; taken on an edge with out_valid high and out_stall low.
// The input register and then the result register lie between an item taken
// on in_* and its appearance on out_*.
// Throughput: one item per cycle while out_stall is low; the decode between
// the two registers is a single pass of opcode compares and immediate muxing.
// Reset (rst_n low, synchronous) empties both registers.
// When out_stall holds, the result register keeps its item and the input
// register may still take one more; in_stall rises only when both are full
// and the result side is stalled.
`include "assert_macros.svh"

module rv32i_control_and_immediate_decode_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  in_opcode,
  input  logic [2:0]  in_funct_three,
  input  logic [6:0]  in_funct_seven,
  input  logic [4:0]  in_rs2_field,
  input  logic [4:0]  in_rd_field,
  input  logic        in_clear,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_jump,
  output logic        out_pc_relative_select,
  output logic        out_reg_write_next,
  output logic        out_branch_flag,
  output logic [3:0]  out_alu_operation,
  output logic        out_alu_uses_immediate,
  output logic        out_store_flag,
  output logic        out_load_flag,
  output logic        out_shift_immediate,
  output logic [11:0] out_immediate,
  output logic        out_reg_write_current
);
  import rvdec_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [6:0] opc_r;
  logic [2:0] f3_r;
  logic [6:0] f7_r;
  logic [4:0] rs2_r;
  logic [4:0] rd_r;
  logic       clr_r;
  logic       s2_valid_r, s2_valid_nxt;
  ctrl_t      ctrl_r;
  ctrl_t      ctrl_nxt;
  logic       s2_load;
  logic       s1_load;

  assign s2_load  = !s2_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  assign ctrl_nxt = decode(opc_r, f3_r, f7_r, rs2_r, rd_r, clr_r);

  always_comb begin
    s1_valid_nxt = s1_load ? in_valid : s1_valid_r;
    s2_valid_nxt = s2_load ? s1_valid_r : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      opc_r <= in_opcode;
      f3_r  <= in_funct_three;
      f7_r  <= in_funct_seven;
      rs2_r <= in_rs2_field;
      rd_r  <= in_rd_field;
      clr_r <= in_clear;
    end
    if (s2_load && s1_valid_r) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  assign out_valid              = s2_valid_r;
  assign out_jump               = ctrl_r.jump;
  assign out_pc_relative_select = ctrl_r.pc_relative_select;
  assign out_reg_write_next     = ctrl_r.reg_write_next;
  assign out_branch_flag        = ctrl_r.branch_flag;
  assign out_alu_operation      = ctrl_r.alu_operation;
  assign out_alu_uses_immediate = ctrl_r.alu_uses_immediate;
  assign out_store_flag         = ctrl_r.store_flag;
  assign out_load_flag          = ctrl_r.load_flag;
  assign out_shift_immediate    = ctrl_r.shift_immediate;
  assign out_immediate          = ctrl_r.immediate;
  assign out_reg_write_current  = ctrl_r.reg_write_current;

  `ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid_r && s2_valid_r && out_stall, "input stalled while a register is free")
  `ASSERT_NEXT(a_s1_drains, clk, rst_n, s1_valid_r && s2_load, out_valid, "input register item not moved to result")
  `ASSERT_SAME(a_store_sets_branch, clk, rst_n, out_valid && out_store_flag, out_branch_flag, "store without branch flag")
  `ASSERT_SAME(a_jump_writes, clk, rst_n, out_valid && out_jump, out_reg_write_current, "jump without current-stage write")

endmodule
